[hdl/mbrf_pkg.sv]
package mbrf_pkg;

   localparam int unsigned COUNT_LSB   = 24;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned DATA_W      = 24;
   localparam int unsigned FREE_MARGIN = 3;

   localparam logic OP_WORD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic                op;
      logic [1:0]          count;
      logic [DATA_W-1:0]   bytes;
      logic                end_of_read;
   } cmd_type;

   typedef struct packed {
      logic                byte_valid;
      logic [BYTE_W-1:0]   read_byte;
      logic                fifo_empty;
      logic                mailbox_ack;
      logic                rx_irq_enabled;
   } rsp_type;

endpackage

[hdl/mbrf_req_if.sv]
interface mbrf_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] mailbox_word;
   logic        end_of_read;

   modport source (output valid, output opcode, output mailbox_word, output end_of_read,
                   input ready);
   modport sink   (input valid, input opcode, input mailbox_word, input end_of_read,
                   output ready);
endinterface

[hdl/mbrf_rsp_if.sv]
interface mbrf_rsp_if;
   logic       valid;
   logic       ready;
   logic       byte_valid;
   logic [7:0] read_byte;
   logic       fifo_empty;
   logic       mailbox_ack;
   logic       rx_irq_enabled;

   modport source (output valid, output byte_valid, output read_byte, output fifo_empty,
                   output mailbox_ack, output rx_irq_enabled, input ready);
   modport sink   (input valid, input byte_valid, input read_byte, input fifo_empty,
                   input mailbox_ack, input rx_irq_enabled, output ready);
endinterface

[hdl/mbrf_ram.sv]
module mbrf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/mbrf_front.sv]
module mbrf_front (
   input  logic             clock,
   input  logic             reset,
   mbrf_req_if.sink         req_port,
   output mbrf_pkg::cmd_type cmd_out,
   output logic             cmd_valid,
   input  logic             cmd_pop
);

   mbrf_pkg::cmd_type q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   mbrf_pkg::cmd_type cmd_new;
   logic              push;
   logic              pop;

   // decode the transfer into a command
   always_comb begin
      cmd_new.op          = req_port.opcode;
      cmd_new.count       = req_port.mailbox_word[mbrf_pkg::COUNT_LSB +: 2];
      cmd_new.bytes       = req_port.mailbox_word[mbrf_pkg::DATA_W-1:0];
      cmd_new.end_of_read = req_port.end_of_read;
   end

   assign req_port.ready = (cnt_ff != 2'd2);
   assign push           = req_port.valid && req_port.ready;
   assign pop            = cmd_pop && (cnt_ff != 2'd0);
   assign cmd_valid      = (cnt_ff != 2'd0);
   assign cmd_out        = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

[hdl/mbrf_back.sv]
module mbrf_back #(
   parameter int unsigned FIFO_DEPTH = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  mbrf_pkg::cmd_type cmd_in,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   mbrf_rsp_if.source        rsp_port
);

   localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_IDX  = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(FIFO_DEPTH);
   // free slots > margin  <=>  fill < depth - margin
   localparam logic [CNT_W-1:0] ACK_LIMIT = CNT_W'(FIFO_DEPTH - mbrf_pkg::FREE_MARGIN);

   localparam logic [1:0] S_IDLE     = 2'd0;
   localparam logic [1:0] S_PUSH     = 2'd1;
   localparam logic [1:0] S_WORD_END = 2'd2;
   localparam logic [1:0] S_READ     = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [PTR_W-1:0]            head_ff, head_in;
   logic [PTR_W-1:0]            tail_ff, tail_in;
   logic [CNT_W-1:0]            fill_ff, fill_in;
   logic                        pend_ff, pend_in;
   logic                        irq_en_ff, irq_en_in;
   logic [1:0]                  rem_ff, rem_in;
   logic [mbrf_pkg::DATA_W-1:0] bytes_ff, bytes_in;
   logic                        eor_ff, eor_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   mbrf_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic                        wr_en;
   logic                        rd_en;
   logic [mbrf_pkg::BYTE_W-1:0] rd_data;
   logic [CNT_W-1:0]            fill_dec;
   logic                        release_rd;

   mbrf_ram #(
      .WIDTH (mbrf_pkg::BYTE_W),
      .DEPTH (FIFO_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (bytes_ff[mbrf_pkg::BYTE_W-1:0]),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   assign fill_dec   = fill_ff - CNT_W'(1);
   assign release_rd = eor_ff && pend_ff && (fill_dec < ACK_LIMIT);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      pend_in      = pend_ff;
      irq_en_in    = irq_en_ff;
      rem_in       = rem_ff;
      bytes_in     = bytes_ff;
      eor_in       = eor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_data_in  = rsp_data_ff;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            // take a command only once the output register is free
            if (cmd_valid && !rsp_valid_ff) begin
               cmd_pop = 1'b1;
               eor_in  = cmd_in.end_of_read;
               if (cmd_in.op == mbrf_pkg::OP_WORD) begin
                  if (irq_en_ff) begin
                     rem_in   = cmd_in.count;
                     bytes_in = cmd_in.bytes;
                     state_in = (cmd_in.count == 2'd0) ? S_WORD_END : S_PUSH;
                  end else begin
                     // masked: word dropped
                     rsp_valid_in               = 1'b1;
                     rsp_data_in.byte_valid     = 1'b0;
                     rsp_data_in.read_byte      = '0;
                     rsp_data_in.fifo_empty     = (fill_ff == '0);
                     rsp_data_in.mailbox_ack    = 1'b0;
                     rsp_data_in.rx_irq_enabled = irq_en_ff;
                  end
               end else if (fill_ff != '0) begin
                  rd_en    = 1'b1;
                  state_in = S_READ;
               end else begin
                  // empty read still runs the end-of-batch release test
                  rsp_valid_in               = 1'b1;
                  rsp_data_in.byte_valid     = 1'b0;
                  rsp_data_in.read_byte      = '0;
                  rsp_data_in.fifo_empty     = 1'b1;
                  rsp_data_in.mailbox_ack    = 1'b0;
                  rsp_data_in.rx_irq_enabled = irq_en_ff;
                  if (cmd_in.end_of_read && pend_ff && (fill_ff < ACK_LIMIT)) begin
                     pend_in                    = 1'b0;
                     irq_en_in                  = 1'b1;
                     rsp_data_in.mailbox_ack    = 1'b1;
                     rsp_data_in.rx_irq_enabled = 1'b1;
                  end
               end
            end
         end
         S_PUSH: begin
            // one byte per cycle, dropped when full
            if (fill_ff != FULL_CNT) begin
               wr_en   = 1'b1;
               tail_in = (tail_ff == LAST_IDX) ? '0 : tail_ff + PTR_W'(1);
               fill_in = fill_ff + CNT_W'(1);
            end
            bytes_in = bytes_ff >> mbrf_pkg::BYTE_W;
            rem_in   = rem_ff - 2'd1;
            if (rem_ff == 2'd1) begin
               state_in = S_WORD_END;
            end
         end
         S_WORD_END: begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.byte_valid = 1'b0;
            rsp_data_in.read_byte  = '0;
            rsp_data_in.fifo_empty = (fill_ff == '0);
            if (fill_ff < ACK_LIMIT) begin
               rsp_data_in.mailbox_ack    = 1'b1;
               rsp_data_in.rx_irq_enabled = irq_en_ff;
            end else begin
               pend_in                    = 1'b1;
               irq_en_in                  = 1'b0;
               rsp_data_in.mailbox_ack    = 1'b0;
               rsp_data_in.rx_irq_enabled = 1'b0;
            end
            state_in = S_IDLE;
         end
         S_READ: begin
            head_in                    = (head_ff == LAST_IDX) ? '0 : head_ff + PTR_W'(1);
            fill_in                    = fill_dec;
            rsp_valid_in               = 1'b1;
            rsp_data_in.byte_valid     = 1'b1;
            rsp_data_in.read_byte      = rd_data;
            rsp_data_in.fifo_empty     = (fill_dec == '0);
            rsp_data_in.mailbox_ack    = release_rd;
            rsp_data_in.rx_irq_enabled = irq_en_ff || release_rd;
            if (release_rd) begin
               pend_in   = 1'b0;
               irq_en_in = 1'b1;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         irq_en_ff    <= 1'b1;
         rem_ff       <= 2'd0;
         eor_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         irq_en_ff    <= irq_en_in;
         rem_ff       <= rem_in;
         eor_ff       <= eor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff    <= bytes_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.byte_valid     = rsp_data_ff.byte_valid;
   assign rsp_port.read_byte      = rsp_data_ff.read_byte;
   assign rsp_port.fifo_empty     = rsp_data_ff.fifo_empty;
   assign rsp_port.mailbox_ack    = rsp_data_ff.mailbox_ack;
   assign rsp_port.rx_irq_enabled = rsp_data_ff.rx_irq_enabled;

endmodule

[hdl/mailbox_byte_receive_fifo_unit.sv]
// Mailbox word to byte FIFO with receive flow control.
// req_port: opcode 0 delivers a mailbox word (count in bits 25:24, up to three
//   bytes in bits 23:0, low byte first); opcode 1 pops one byte, end_of_read
//   marks the last request of a read batch.
// rsp_port: exactly one result per request, in request order: popped byte and
//   its valid flag, FIFO empty, mailbox release and the interrupt enable.
// A two-entry command queue sits in front of the executing back end, so
//   requests are taken while the back end works or a result waits.
// Execution: a word writes its bytes to the FIFO RAM one byte per cycle and
//   then gives its result; a read gives its byte through the registered RAM
//   read. One request is executed at a time and the back end takes the next
//   one only after the result register has emptied.
// Reset empties the FIFO, clears the pending release and enables the
//   interrupt; FIFO RAM contents are not cleared.
// When the receiver stalls, the result holds in the output register and the
//   back end stops; requests keep being taken until the queue is full.
module mailbox_byte_receive_fifo_unit #(
   parameter int unsigned FIFO_DEPTH = 128
) (
   input  logic       clock,
   input  logic       reset,
   mbrf_req_if.sink   req_port,
   mbrf_rsp_if.source rsp_port
);

   mbrf_pkg::cmd_type cmd;
   logic              cmd_valid;
   logic              cmd_pop;

   mbrf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_port),
      .cmd_out   (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop)
   );

   mbrf_back #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_in    (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp_port  (rsp_port)
   );

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

   localparam int unsigned FIFO_DEPTH  = 128;
   localparam int unsigned PTR_W       = $clog2(FIFO_DEPTH);
   localparam int unsigned RAND_ITEMS  = 1100;
   localparam int unsigned CALM_ITEMS  = 150;
   localparam int unsigned IDLE_LIMIT  = 2000;
   localparam int unsigned DRAIN_WAIT  = 20;
   localparam int unsigned MAX_REPORTS = 10;

   typedef struct {
      logic        op;
      logic [31:0] word;
      logic        eor;
      int unsigned gap;
      bit          drain;
   } mbx_req_type;

   logic clock;
   logic reset;

   mbrf_req_if req_bus();
   mbrf_rsp_if rsp_bus();

   mailbox_byte_receive_fifo_unit #(.FIFO_DEPTH(FIFO_DEPTH)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // shadow copy of the receive FIFO and its flow-control flags
   logic [7:0]       sh_bytes [FIFO_DEPTH];
   logic [PTR_W-1:0] sh_head;
   logic [PTR_W-1:0] sh_tail;
   int unsigned      sh_fill;
   bit               sh_pending;
   bit               sh_irq_en;

   mbx_req_type       pend_q[$];
   mbrf_pkg::rsp_type rx_results_due[$];

   int unsigned mismatches;
   int unsigned idle_cycles;
   int unsigned gap_cnt;
   int unsigned stall_left;
   int unsigned words_taken, reads_taken, masked_words, empty_reads, acks_due;
   int unsigned idle_style;
   bit          gen_calm;
   bit          req_taken;
   bit          calm;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic mbrf_pkg::rsp_type next_rx_result(logic op, logic [31:0] word,
                                                        logic eor);
      mbrf_pkg::rsp_type r;
      int unsigned       n;
      r = '0;
      if (op == mbrf_pkg::OP_WORD) begin
         words_taken++;
         if (sh_irq_en) begin
            n = {30'd0, word[mbrf_pkg::COUNT_LSB +: 2]};
            for (int i = 0; i < n; i++) begin
               // a byte that finds the FIFO full is dropped
               if (sh_fill < FIFO_DEPTH) begin
                  sh_bytes[sh_tail] = word[i*mbrf_pkg::BYTE_W +: mbrf_pkg::BYTE_W];
                  sh_tail = (sh_tail == PTR_W'(FIFO_DEPTH - 1)) ? '0 : sh_tail + 1'b1;
                  sh_fill++;
               end
            end
            if (FIFO_DEPTH - sh_fill > mbrf_pkg::FREE_MARGIN) begin
               r.mailbox_ack = 1'b1;
            end else begin
               sh_pending = 1'b1;
               sh_irq_en  = 1'b0;
            end
         end else begin
            masked_words++;
         end
      end else begin
         reads_taken++;
         if (sh_fill > 0) begin
            r.byte_valid = 1'b1;
            r.read_byte  = sh_bytes[sh_head];
            sh_head = (sh_head == PTR_W'(FIFO_DEPTH - 1)) ? '0 : sh_head + 1'b1;
            sh_fill--;
         end else begin
            empty_reads++;
         end
         if (eor && sh_pending && (FIFO_DEPTH - sh_fill > mbrf_pkg::FREE_MARGIN)) begin
            r.mailbox_ack = 1'b1;
            sh_pending = 1'b0;
            sh_irq_en  = 1'b1;
         end
      end
      if (r.mailbox_ack) acks_due++;
      r.fifo_empty     = (sh_fill == 0);
      r.rx_irq_enabled = sh_irq_en;
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      if (gen_calm || idle_style == 0) return 0;
      if ($urandom_range(0, idle_style == 2 ? 2 : 7) == 0) return $urandom_range(1, 14);
      return 0;
   endfunction

   task automatic queue_req(logic op, logic [31:0] word, logic eor, bit drain);
      mbx_req_type it;
      it.op    = op;
      it.word  = word;
      it.eor   = eor;
      it.gap   = pick_gap();
      it.drain = drain;
      pend_q.push_back(it);
   endtask

   function automatic logic [31:0] mbx_word(int unsigned cnt);
      logic [31:0] w;
      w = $urandom();
      w[mbrf_pkg::COUNT_LSB +: 2] = cnt[1:0];
      return w;
   endfunction

   // stimulus and end of run
   initial begin
      int unsigned made;
      int unsigned len;
      int unsigned cnt;
      req_bus.valid        = 1'b0;
      req_bus.opcode       = mbrf_pkg::OP_WORD;
      req_bus.mailbox_word = '0;
      req_bus.end_of_read  = 1'b0;
      rsp_bus.ready        = 1'b0;
      reset                = 1'b1;
      gen_calm             = 1'b0;
      idle_style           = 1;

      // directed: empty reads, zero counts, every count, extreme words
      queue_req(mbrf_pkg::OP_READ, 32'h0000_0000, 1'b1, 1'b0);
      queue_req(mbrf_pkg::OP_READ, 32'hffff_ffff, 1'b0, 1'b0);
      queue_req(mbrf_pkg::OP_WORD, 32'h0000_0000, 1'b0, 1'b0);
      queue_req(mbrf_pkg::OP_WORD, 32'hfcff_ffff, 1'b1, 1'b0);
      queue_req(mbrf_pkg::OP_WORD, 32'h0100_00a5, 1'b0, 1'b0);
      queue_req(mbrf_pkg::OP_WORD, 32'h0200_ff00, 1'b0, 1'b0);
      queue_req(mbrf_pkg::OP_WORD, 32'hffff_ffff, 1'b0, 1'b0);
      queue_req(mbrf_pkg::OP_WORD, 32'h0312_3456, 1'b0, 1'b0);
      queue_req(mbrf_pkg::OP_WORD, 32'hfe80_0001, 1'b0, 1'b0);
      for (int i = 0; i < 9; i++) queue_req(mbrf_pkg::OP_READ, 32'h0, 1'b0, 1'b0);
      queue_req(mbrf_pkg::OP_READ, 32'h0, 1'b1, 1'b0);
      queue_req(mbrf_pkg::OP_READ, 32'h0, 1'b1, 1'b0);
      queue_req(mbrf_pkg::OP_WORD, 32'h0155_5555, 1'b0, 1'b0);
      queue_req(mbrf_pkg::OP_READ, 32'h0, 1'b1, 1'b0);

      // random: bursts of mailbox words, then read batches closed by an end mark
      made = 0;
      while (made < RAND_ITEMS) begin
         idle_style = $urandom_range(0, 2);
         len = $urandom_range(1, 50);
         for (int i = 0; i < len && made < RAND_ITEMS; i++) begin
            gen_calm = (made >= RAND_ITEMS - CALM_ITEMS);
            cnt = ($urandom_range(0, 9) < 6) ? 3 : $urandom_range(0, 2);
            if ($urandom_range(0, 15) == 0) begin
               queue_req(mbrf_pkg::OP_READ, $urandom(), 1'($urandom_range(0, 1)), made == 0);
            end else begin
               queue_req(mbrf_pkg::OP_WORD, mbx_word(cnt), 1'($urandom_range(0, 1)),
                         made == 0);
            end
            made++;
         end
         len = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 20);
         for (int i = 0; i < len && made < RAND_ITEMS; i++) begin
            gen_calm = (made >= RAND_ITEMS - CALM_ITEMS);
            queue_req(mbrf_pkg::OP_READ, $urandom(),
                      (i == len - 1) || ($urandom_range(0, 9) == 0),
                      $urandom_range(0, 99) == 0);
            made++;
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pend_q.size() != 0 || req_bus.valid || rx_results_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d mailbox words (%0d ignored while masked), %0d byte reads",
               words_taken, masked_words, reads_taken);
      $display("%0d reads found the FIFO empty, %0d mailbox releases, %0d mismatches",
               empty_reads, acks_due, mismatches);
      if (mismatches == 0 && rx_results_due.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_cnt = 0;
      end else if (!req_bus.valid || req_taken) begin
         if (pend_q.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else if (gap_cnt < pend_q[0].gap) begin
            req_bus.valid <= 1'b0;
            gap_cnt++;
         end else if (pend_q[0].drain && rx_results_due.size() != 0) begin
            // hold off until every outstanding result is back
            req_bus.valid <= 1'b0;
         end else begin
            req_bus.valid        <= 1'b1;
            req_bus.opcode       <= pend_q[0].op;
            req_bus.mailbox_word <= pend_q[0].word;
            req_bus.end_of_read  <= pend_q[0].eor;
            void'(pend_q.pop_front());
            gap_cnt = 0;
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 14);
      end
   end

   // monitor, prediction and watchdog
   always @(posedge clock) begin
      mbrf_pkg::rsp_type got;
      mbrf_pkg::rsp_type want;
      if (reset) begin
         req_taken   <= 1'b0;
         calm        <= 1'b0;
         idle_cycles = 0;
         mismatches  = 0;
         sh_head     = '0;
         sh_tail     = '0;
         sh_fill     = 0;
         sh_pending  = 1'b0;
         sh_irq_en   = 1'b1;
         words_taken = 0;
         reads_taken = 0;
         masked_words = 0;
         empty_reads = 0;
         acks_due    = 0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         calm      <= (pend_q.size() < CALM_ITEMS);

         if (rsp_bus.valid && rsp_bus.ready) begin
            got.byte_valid     = rsp_bus.byte_valid;
            got.read_byte      = rsp_bus.read_byte;
            got.fifo_empty     = rsp_bus.fifo_empty;
            got.mailbox_ack    = rsp_bus.mailbox_ack;
            got.rx_irq_enabled = rsp_bus.rx_irq_enabled;
            if (rx_results_due.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: unexpected result %p", $realtime, got);
            end else begin
               want = rx_results_due.pop_front();
               if (got.byte_valid !== want.byte_valid || got.read_byte !== want.read_byte ||
                   got.fifo_empty !== want.fifo_empty ||
                   got.mailbox_ack !== want.mailbox_ack ||
                   got.rx_irq_enabled !== want.rx_irq_enabled) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
               end
            end
         end

         if (req_bus.valid && req_bus.ready)
            rx_results_due.push_back(next_rx_result(req_bus.opcode, req_bus.mailbox_word,
                                                    req_bus.end_of_read));

         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                        $realtime, idle_cycles, rx_results_due.size());
               $display("tb NOT OK");
               $finish;
            end
         end
      end
   end

endmodule
